// ===== design/rsa_char_modexp_cipher_unit_macros.svh =====
// Assertion macros shared by the cipher unit.
`ifndef RSA_CHAR_MODEXP_CIPHER_UNIT_MACROS_SVH
`define RSA_CHAR_MODEXP_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RCM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rcm_pkg.sv =====
// Types and constants shared by the cipher unit modules.
package rcm_pkg;

    localparam int WIDTH_DEFAULT = 31;
    localparam int CHAR_BIAS     = 96;
    localparam int CHAR_MAX_CODE = 255;
    localparam int CFG_INDEX_W   = 2;

    localparam logic OPCODE_ENCRYPT = 1'b0;
    localparam logic OPCODE_DECRYPT = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PUBLIC_EXP  = 2'd0,
        CFG_PRIVATE_EXP = 2'd1,
        CFG_MODULUS     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_REDUCE,
        MUL_SQUARE,
        MUL_MULT
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_STEP,
        ST_SQUARE,
        ST_BRANCH,
        ST_MULT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     take_base;
        logic     take_acc;
        logic     exp_shift;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic mul_busy;
        logic mul_done;
        logic exp_bit;
        logic exp_empty;
        logic out_free;
    } status_t;

endpackage

// ===== design/rsa_char_modexp_cipher_unit.sv =====
// Top level of the character RSA modular exponentiation unit.
//
//  channel  direction  tdata (low bit first)          tuser
//  s_*      in         value (WIDTH), zero pad        opcode
//  m_*      out        residue (WIDTH), char_out (8)  error
//  cfg_*    in         cfg_index selects register, cfg_data holds value
//
//  One item at a time. Each item takes a reduction of the value, then a square for
//  every one of the WIDTH exponent bits and a multiply for each set exponent bit,
//  all on the bit-serial modular multiplier (one multiplier bit per cycle).
//  Error and small-modulus items skip these steps and go straight to the result.
//  A finished item sits in the output register; the next item is accepted while
//  it waits. Reset (rst_n low, asynchronous) loads exponents 1 and modulus 2.
`include "rsa_char_modexp_cipher_unit_macros.svh"

module rsa_char_modexp_cipher_unit #(
    parameter int WIDTH = rcm_pkg::WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rcm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [WIDTH-1:0]                     cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((WIDTH+7)/8)*8-1:0]           s_tdata,   // value
    input  logic                                 s_tuser,   // opcode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((WIDTH+8+7)/8)*8-1:0]         m_tdata,   // residue, char_out
    output logic                                 m_tuser    // error
);

    localparam int OUT_W = ((WIDTH + 8 + 7) / 8) * 8;

    rcm_pkg::cmd_t    cmd;
    rcm_pkg::status_t stat;
    logic [WIDTH-1:0] out_residue;
    logic [7:0]       out_char;

    rcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rcm_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_opcode   (s_tuser),
        .in_value    (s_tdata[WIDTH-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_residue (out_residue),
        .out_char    (out_char),
        .out_error   (m_tuser)
    );

    assign m_tdata = OUT_W'({out_char, out_residue});

    `RCM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `RCM_ASSERT_IMP(a_start_when_free, clk, rst_n, cmd.mul_start, !stat.mul_busy, "multiplier restarted while busy")
    `RCM_ASSERT_IMP(a_load_into_free_slot, clk, rst_n, cmd.out_load, stat.out_free, "result overwritten")

endmodule

// ===== design/rcm_modmul.sv =====
// Bit-serial interleaved modular multiplier: a * b mod m, one bit of b per cycle.
module rcm_modmul #(
    parameter int WIDTH = rcm_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam int TW = WIDTH + 2;

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [TW-1:0] sum;
    logic [TW-1:0] m1;
    logic [TW-1:0] m2;
    logic [TW-1:0] reduced;

    // acc < m and a < m, so 2*acc + a stays below 3m
    assign m1  = {2'b00, m};
    assign m2  = {1'b0, m, 1'b0};
    assign sum = {1'b0, acc_reg, 1'b0} + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);

    always_comb
    begin
        if (sum >= m2)
        begin
            reduced = sum - m2;
        end
        else if (sum >= m1)
        begin
            reduced = sum - m1;
        end
        else
        begin
            reduced = sum;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = reduced[WIDTH-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            b_reg <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== design/rcm_datapath.sv =====
// Datapath: key registers, operand selection, exponent shifter and result register.
module rcm_datapath #(
    parameter int WIDTH = rcm_pkg::WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]                cfg_data,
    input  logic                            in_opcode,
    input  logic [WIDTH-1:0]                in_value,
    input  rcm_pkg::cmd_t                   cmd,
    output rcm_pkg::status_t                stat,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [WIDTH-1:0]                out_residue,
    output logic [7:0]                      out_char,
    output logic                            out_error
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] pub_exp_reg;
    logic [WIDTH-1:0] priv_exp_reg;
    logic [WIDTH-1:0] mod_reg;

    logic [WIDTH-1:0] x_reg;
    logic             err_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [CW-1:0]    exp_cnt_reg, exp_cnt_next;

    logic [WIDTH-1:0] res_reg;
    logic [7:0]       chr_reg;
    logic             oerr_reg;
    logic             out_valid_reg, out_valid_next;

    logic             mod_small;
    logic             code_bad;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic             mul_busy;
    logic             mul_done;
    logic [WIDTH-1:0] mul_product;
    logic [WIDTH-1:0] res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_exp_reg  <= WIDTH'(1);
            priv_exp_reg <= WIDTH'(1);
            mod_reg      <= WIDTH'(2);
        end
        else if (cfg_we)
        begin
            case (rcm_pkg::cfg_index_t'(cfg_index))
                rcm_pkg::CFG_PUBLIC_EXP:  pub_exp_reg  <= cfg_data;
                rcm_pkg::CFG_PRIVATE_EXP: priv_exp_reg <= cfg_data;
                rcm_pkg::CFG_MODULUS:     mod_reg      <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign mod_small = (mod_reg[WIDTH-1:1] == '0);
    assign code_bad  = (in_opcode == rcm_pkg::OPCODE_ENCRYPT) &&
                       ((in_value < WIDTH'(rcm_pkg::CHAR_BIAS)) ||
                        (in_value > WIDTH'(rcm_pkg::CHAR_MAX_CODE)));

    always_comb
    begin
        unique case (cmd.mul_sel)
            rcm_pkg::MUL_REDUCE:
            begin
                // x mod m as 1 * x mod m
                mul_a = WIDTH'(1);
                mul_b = x_reg;
            end
            rcm_pkg::MUL_SQUARE:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            rcm_pkg::MUL_MULT:
            begin
                mul_a = base_reg;
                mul_b = acc_reg;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
        endcase
    end

    rcm_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .m       (mod_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= (in_opcode == rcm_pkg::OPCODE_ENCRYPT) ?
                       in_value - WIDTH'(rcm_pkg::CHAR_BIAS) : in_value;
            err_reg <= code_bad;
            exp_reg <= (in_opcode == rcm_pkg::OPCODE_DECRYPT) ? priv_exp_reg : pub_exp_reg;
        end
        else if (cmd.exp_shift)
        begin
            exp_reg <= {exp_reg[WIDTH-2:0], 1'b0};
        end

        if (cmd.take_base)
        begin
            base_reg <= mul_product;
            acc_reg  <= WIDTH'(1);
        end
        else if (cmd.take_acc)
        begin
            acc_reg <= mul_product;
        end

        if (cmd.out_load)
        begin
            res_reg  <= res_next;
            chr_reg  <= err_reg ? 8'd0 : res_next[7:0] + 8'(rcm_pkg::CHAR_BIAS);
            oerr_reg <= err_reg;
        end
    end

    assign res_next = (err_reg || mod_small) ? '0 : acc_reg;

    always_comb
    begin
        exp_cnt_next = exp_cnt_reg;
        if (cmd.load)
        begin
            exp_cnt_next = CW'(WIDTH);
        end
        else if (cmd.exp_shift)
        begin
            exp_cnt_next = exp_cnt_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exp_cnt_reg   <= exp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.skip      = err_reg || mod_small;
    assign stat.mul_busy  = mul_busy;
    assign stat.mul_done  = mul_done;
    assign stat.exp_bit   = exp_reg[WIDTH-1];
    assign stat.exp_empty = (exp_cnt_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_residue = res_reg;
    assign out_char    = chr_reg;
    assign out_error   = oerr_reg;

endmodule

// ===== design/rcm_ctrl.sv =====
// Controller: sequences reduction, square and multiply steps for one item.
module rcm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rcm_pkg::status_t stat,
    output rcm_pkg::cmd_t    cmd
);

    rcm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rcm_pkg::ST_CHECK;
                end
            end
            rcm_pkg::ST_CHECK:
            begin
                state_next = stat.skip ? rcm_pkg::ST_FINISH : rcm_pkg::ST_REDUCE;
            end
            rcm_pkg::ST_REDUCE:
            begin
                if (stat.mul_done)
                begin
                    state_next = rcm_pkg::ST_STEP;
                end
            end
            rcm_pkg::ST_STEP:
            begin
                state_next = stat.exp_empty ? rcm_pkg::ST_FINISH : rcm_pkg::ST_SQUARE;
            end
            rcm_pkg::ST_SQUARE:
            begin
                if (stat.mul_done)
                begin
                    state_next = rcm_pkg::ST_BRANCH;
                end
            end
            rcm_pkg::ST_BRANCH:
            begin
                state_next = stat.exp_bit ? rcm_pkg::ST_MULT : rcm_pkg::ST_STEP;
            end
            rcm_pkg::ST_MULT:
            begin
                if (stat.mul_done)
                begin
                    state_next = rcm_pkg::ST_STEP;
                end
            end
            rcm_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = rcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.mul_sel   = rcm_pkg::MUL_REDUCE;
        unique case (state_reg)
            rcm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rcm_pkg::ST_CHECK:
            begin
                cmd.mul_start = !stat.skip;
                cmd.mul_sel   = rcm_pkg::MUL_REDUCE;
            end
            rcm_pkg::ST_REDUCE:
            begin
                cmd.take_base = stat.mul_done;
            end
            rcm_pkg::ST_STEP:
            begin
                cmd.mul_start = !stat.exp_empty;
                cmd.mul_sel   = rcm_pkg::MUL_SQUARE;
            end
            rcm_pkg::ST_SQUARE:
            begin
                cmd.take_acc = stat.mul_done;
            end
            rcm_pkg::ST_BRANCH:
            begin
                // set bit: multiply by base; clear bit: advance to next bit
                cmd.mul_start = stat.exp_bit;
                cmd.mul_sel   = rcm_pkg::MUL_MULT;
                cmd.exp_shift = !stat.exp_bit;
            end
            rcm_pkg::ST_MULT:
            begin
                cmd.take_acc  = stat.mul_done;
                cmd.exp_shift = stat.mul_done;
            end
            rcm_pkg::ST_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
